// ----- src/assert_macros.svh -----
// Assertion macros shared by the CBOR head encoder RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define CHK_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond_a on one edge implies cond_b on the next edge.
`define CHK_NEXT(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_b)) \
    else $error(msg);

`endif

// ----- src/cbhe_pkg.sv -----
// Package for the CBOR head encoder: transaction types, mode codes and constants.
// No dependencies.
`default_nettype none

package cbhe_pkg;

  // Mode codes of the func field
  localparam logic [2:0] FUNC_SHORTEST = 3'd0;
  localparam logic [2:0] FUNC_ARG8     = 3'd1;
  localparam logic [2:0] FUNC_ARG16    = 3'd2;
  localparam logic [2:0] FUNC_ARG32    = 3'd3;
  localparam logic [2:0] FUNC_ARG64    = 3'd4;
  localparam logic [2:0] FUNC_RAW      = 3'd5;

  // Additional-information codes
  localparam logic [4:0] AI_ONE_BYTE   = 5'd24;
  localparam logic [4:0] AI_TWO_BYTE   = 5'd25;
  localparam logic [4:0] AI_FOUR_BYTE  = 5'd26;
  localparam logic [4:0] AI_EIGHT_BYTE = 5'd27;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  major_type;
    logic [63:0] arg_value;
    logic [7:0]  raw_byte;
    logic [15:0] room;
  } cbhe_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       fits;
    logic [3:0] head_len;
  } cbhe_out_t;

  // Classified command: head byte, argument left-aligned (next byte on top)
  typedef struct packed {
    logic [7:0]  head;
    logic [63:0] arg;
    logic [3:0]  nargs;
    logic [3:0]  head_len;
    logic        fits;
  } cbhe_cmd_t;

endpackage

`default_nettype wire

// ----- src/cbhe_front.sv -----
// Front end: accepts requests, classifies them into head commands.
// Depends on cbhe_pkg.
`default_nettype none

module cbhe_front import cbhe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire cbhe_in_t   in_item,
  input  wire logic       q_full,
  output logic            q_push,
  output cbhe_cmd_t       q_cmd
);

  logic      valid_r, valid_nxt;
  cbhe_cmd_t cmd_r, cmd_nxt;
  logic      accept;

  logic [4:0]  ai;
  logic [3:0]  nargs;
  logic [3:0]  len;
  logic [7:0]  head;
  logic [63:0] arg_al;
  logic [63:0] v;

  assign busy   = valid_r && q_full;
  assign accept = start && !busy;
  assign q_push = valid_r && !q_full;
  assign q_cmd  = cmd_r;

  // Classify the request
  always_comb begin
    v     = in_item.arg_value;
    ai    = 5'd0;
    nargs = 4'd0;
    unique case (in_item.func)
      FUNC_ARG8: begin
        v = {56'd0, in_item.arg_value[7:0]};
        if (in_item.arg_value[7:0] < 8'd24) begin
          ai = in_item.arg_value[4:0];
        end else begin
          ai    = AI_ONE_BYTE;
          nargs = 4'd1;
        end
      end
      FUNC_ARG16: begin
        ai    = AI_TWO_BYTE;
        nargs = 4'd2;
      end
      FUNC_ARG32: begin
        ai    = AI_FOUR_BYTE;
        nargs = 4'd4;
      end
      FUNC_ARG64: begin
        ai    = AI_EIGHT_BYTE;
        nargs = 4'd8;
      end
      FUNC_RAW: begin
        ai    = 5'd0;
        nargs = 4'd0;
      end
      default: begin
        if (v < 64'd24) begin
          ai = v[4:0];
        end else if (v <= 64'hFF) begin
          ai    = AI_ONE_BYTE;
          nargs = 4'd1;
        end else if (v <= 64'hFFFF) begin
          ai    = AI_TWO_BYTE;
          nargs = 4'd2;
        end else if (v <= 64'hFFFF_FFFF) begin
          ai    = AI_FOUR_BYTE;
          nargs = 4'd4;
        end else begin
          ai    = AI_EIGHT_BYTE;
          nargs = 4'd8;
        end
      end
    endcase

    head = (in_item.func == FUNC_RAW) ? in_item.raw_byte : {in_item.major_type, ai};
    len  = nargs + 4'd1;

    // Left-align the argument so its most significant byte leaves first
    case (nargs)
      4'd1:    arg_al = {v[7:0], 56'd0};
      4'd2:    arg_al = {v[15:0], 48'd0};
      4'd4:    arg_al = {v[31:0], 32'd0};
      default: arg_al = v;
    endcase

    if (in_item.room < {12'd0, len}) begin
      cmd_nxt.head     = 8'd0;
      cmd_nxt.arg      = 64'd0;
      cmd_nxt.nargs    = 4'd0;
      cmd_nxt.head_len = 4'd0;
      cmd_nxt.fits     = 1'b0;
    end else begin
      cmd_nxt.head     = head;
      cmd_nxt.arg      = arg_al;
      cmd_nxt.nargs    = nargs;
      cmd_nxt.head_len = len;
      cmd_nxt.fits     = 1'b1;
    end
  end

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/cbhe_queue.sv -----
// Command queue between front end and byte emitter.
// Depends on cbhe_pkg and assert_macros.svh.
`default_nettype none

module cbhe_queue import cbhe_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire cbhe_cmd_t push_cmd,
  input  wire logic      pop,
  output logic           full,
  output logic           empty,
  output cbhe_cmd_t      head_cmd
);
`include "assert_macros.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cbhe_cmd_t       entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  `CHK_CLK(a_no_overflow, !(push && full), "queue push while full")
  `CHK_CLK(a_no_underflow, !(pop && empty), "queue pop while empty")

endmodule

`default_nettype wire

// ----- src/cbhe_back.sv -----
// Byte emitter: pops head commands and sends one byte per cycle.
// Depends on cbhe_pkg and assert_macros.svh.
`default_nettype none

module cbhe_back import cbhe_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_empty,
  input  wire cbhe_cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_strobe,
  output cbhe_out_t      out_item
);
`include "assert_macros.svh"

  logic [3:0]  remaining_r, remaining_nxt;
  logic [63:0] shift_r, shift_nxt;
  logic [3:0]  len_r, len_nxt;
  logic        strobe_r, strobe_nxt;
  cbhe_out_t   item_r, item_nxt;

  assign q_pop      = (remaining_r == 4'd0) && !q_empty;
  assign out_strobe = strobe_r;
  assign out_item   = item_r;

  always_comb begin
    remaining_nxt = remaining_r;
    shift_nxt     = shift_r;
    len_nxt       = len_r;
    strobe_nxt    = 1'b0;
    item_nxt      = item_r;
    if (remaining_r != 4'd0) begin
      // Advance through argument bytes, most significant first
      strobe_nxt         = 1'b1;
      item_nxt.out_byte  = shift_r[63:56];
      item_nxt.last_byte = (remaining_r == 4'd1);
      item_nxt.fits      = 1'b1;
      item_nxt.head_len  = len_r;
      shift_nxt          = {shift_r[55:0], 8'h00};
      remaining_nxt      = remaining_r - 4'd1;
    end else if (!q_empty) begin
      strobe_nxt         = 1'b1;
      item_nxt.out_byte  = q_cmd.head;
      item_nxt.last_byte = (q_cmd.nargs == 4'd0);
      item_nxt.fits      = q_cmd.fits;
      item_nxt.head_len  = q_cmd.head_len;
      shift_nxt          = q_cmd.arg;
      remaining_nxt      = q_cmd.nargs;
      len_nxt            = q_cmd.head_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= 4'd0;
      strobe_r    <= 1'b0;
    end else begin
      remaining_r <= remaining_nxt;
      strobe_r    <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    len_r   <= len_nxt;
    item_r  <= item_nxt;
  end

  `CHK_CLK(a_rem_range, remaining_r <= 4'd8, "argument byte count out of range")
  `CHK_CLK(a_more_follow, !(strobe_r && !item_r.last_byte) || (remaining_r != 4'd0),
    "non-final byte sent with nothing pending")
  `CHK_CLK(a_nofit_len, !(strobe_r && !item_r.fits) || (item_r.head_len == 4'd0 &&
    item_r.last_byte), "no-room result must be a single zero-length result")
  `CHK_NEXT(a_arg_follows, strobe_r && !item_r.last_byte, strobe_r,
    "gap inside a head")

endmodule

`default_nettype wire

// ----- src/cbhe_top.sv -----
// Core of the CBOR head encoder: wires the front end, command queue and byte emitter.
// Depends on cbhe_pkg, cbhe_front, cbhe_queue, cbhe_back.
`default_nettype none

module cbhe_top import cbhe_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire cbhe_in_t in_item,
  output logic          out_strobe,
  output cbhe_out_t     out_item
);

  cbhe_cmd_t push_cmd, head_cmd;
  logic      push, pop, full, empty;

  // Classify requests and hold one until the queue has room
  cbhe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_full  (full),
    .q_push  (push),
    .q_cmd   (push_cmd)
  );

  cbhe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head_cmd (head_cmd)
  );

  cbhe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (empty),
    .q_cmd      (head_cmd),
    .q_pop      (pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

// ----- src/cbor_head_encoder_top.sv -----
// Top level of the CBOR head encoder: front end, command queue, byte emitter.
// Depends on cbhe_pkg and cbhe_top.
//
//   channel | ports                      | handshake
//   --------+----------------------------+-------------------------------------
//   request | start, busy, in_item       | transaction taken when start && !busy
//   result  | out_strobe, out_item       | one byte per strobe cycle, no stall
//
// Each request yields one result per head byte (1, 2, 3, 5 or 9 bytes), or a
// single result when the head does not fit; the byte emitter sends one byte
// per cycle while commands are queued, and requests are taken during a head.
// The first byte passes the front register, then a queue entry, then the
// output register; a full queue can hold it in the front register.
// Reset (rst_n low, synchronous) empties the front register and the queue.
// busy rises only when the front register holds a command and the queue is
// full; the receiver never stalls the emitter.
`default_nettype none

module cbor_head_encoder_top import cbhe_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire cbhe_in_t in_item,
  output logic          out_strobe,
  output cbhe_out_t     out_item
);

  // Hand everything to the core; the queue depth sets how many classified
  // transactions can wait behind the one being emitted.
  cbhe_top #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire
